// ----- design/ulat_pkg.sv -----
`default_nettype none
package ulat_pkg;

   localparam int ULAT_LINE_CAPACITY = 64;
   localparam int ULAT_QUEUE_DEPTH   = 4;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_LOW   = 8'd32;
   localparam logic [7:0] CH_HIGH  = 8'd126;
   localparam logic [6:0] CH_SPACE = 7'd32;

   typedef enum logic {
      OP_WRITE,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] ch;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } back_state_type;

endpackage
`default_nettype wire

// ----- design/ulat_front.sv -----
`default_nettype none
module ulat_front (
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_rx_byte,
   input  wire ulat_pkg::q_status_type q_status,
   output logic                       push,
   output ulat_pkg::cmd_type          push_cmd
);
   import ulat_pkg::*;

   logic is_print;
   logic is_lf;

   always_comb begin
      is_print = (req_rx_byte >= CH_LOW) && (req_rx_byte <= CH_HIGH);
      is_lf    = (req_rx_byte == CH_LF);
      // carriage return, tab and other control bytes fall out here
      req_ready   = !q_status.full;
      push        = req_valid && req_ready && (is_print || is_lf);
      push_cmd.op = is_lf ? OP_FLUSH : OP_WRITE;
      push_cmd.ch = req_rx_byte[6:0];
   end

endmodule
`default_nettype wire

// ----- design/ulat_queue.sv -----
`default_nettype none
module ulat_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ulat_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output ulat_pkg::cmd_type      pop_cmd,
   output ulat_pkg::q_status_type status
);
   import ulat_pkg::*;

   localparam int DEPTH = ULAT_QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      status.valid = (count_ff != '0);
      status.full  = (count_ff == CNT_W'(DEPTH));
      do_push      = push && !status.full;
      do_pop       = pop && status.valid;
      pop_cmd      = slot_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/ulat_back.sv -----
`default_nettype none
module ulat_back #(
   parameter int LINE_CAPACITY = ulat_pkg::ULAT_LINE_CAPACITY
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ulat_pkg::q_status_type q_status,
   input  wire ulat_pkg::cmd_type      q_cmd,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [6:0]                  rsp_line_char,
   output logic                        rsp_line_last
);
   import ulat_pkg::*;

   localparam int IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   logic [6:0]       line_mem [LINE_CAPACITY];

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             seen_ff, seen_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       char_ff;
   logic             last_flag_ff;

   logic             out_free;
   logic             rd_en;
   logic             rd_last;
   logic             wr_en;
   logic             line_full;
   logic             clear;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.valid && q_cmd.op == OP_FLUSH && seen_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rd_en && rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      rd_last   = (rd_idx_ff == last_ff);
      line_full = (fill_ff == IDX_W'(LINE_CAPACITY - 1));
      pop       = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      clear     = 1'b0;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pop = q_status.valid;
            if (pop) begin
               unique case (q_cmd.op)
                  OP_WRITE: begin
                     wr_en = !line_full;
                     clear = line_full;
                  end
                  OP_FLUSH: begin
                     clear     = !seen_ff;
                     rd_idx_in = first_ff;
                  end
                  default: clear = 1'b0;
               endcase
            end
         end
         ST_DRAIN: begin
            rd_en = out_free;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               clear     = rd_last;
            end
         end
         default: clear = 1'b0;
      endcase

      fill_in  = fill_ff;
      first_in = first_ff;
      last_in  = last_ff;
      seen_in  = seen_ff;
      if (clear) begin
         fill_in  = '0;
         first_in = '0;
         last_in  = '0;
         seen_in  = 1'b0;
      end else if (wr_en) begin
         fill_in = fill_ff + 1'b1;
         if (q_cmd.ch != CH_SPACE) begin
            if (!seen_ff) begin
               first_in = fill_ff;
            end
            seen_in = 1'b1;
            last_in = fill_ff;
         end
      end

      if (rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // store write, and read straight into the output word register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff] <= q_cmd.ch;
      end
      if (rd_en) begin
         char_ff      <= line_mem[rd_idx_ff];
         last_flag_ff <= rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         first_ff     <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_char = char_ff;
   assign rsp_line_last = last_flag_ff;

`ifndef SYNTH
   a_text_bounds: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (first_ff <= last_ff) && (last_ff < fill_ff))
      else $error("text indices out of order");

   a_drain_has_text: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> seen_ff)
      else $error("draining a line without text");

   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rd_idx_ff >= first_ff) && (rd_idx_ff <= last_ff))
      else $error("read index outside trimmed text");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rd_en && rd_last) |=> (state_ff == ST_IDLE) && (fill_ff == '0) && rsp_valid_ff
         && rsp_line_last)
      else $error("line end did not empty the store");

   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !pop && !wr_en)
      else $error("store changed during drain");
`endif

endmodule
`default_nettype wire

// ----- design/uart_line_assembler_trim_core.sv -----
`default_nettype none
// Serial line assembler with space trimming.
// req channel: one received byte per word (req_rx_byte), valid/ready.
//   Printable bytes 32..126 are stored; line feed closes the line; carriage
//   return, tab, other control bytes and bytes above 126 are dropped.
//   A printable byte arriving with LINE_CAPACITY-1 characters stored
//   discards the whole line and itself.
// rsp channel: the closed line without leading and trailing spaces, one
//   character per word (rsp_line_char), rsp_line_last on the final one.
//   Blank or space-only lines give no words.
// Timing: a byte is taken into a 4-word command queue; the line engine
//   retires one queued byte per cycle while it is not draining a line.
//   After a line feed the first character passes the queue, the drain
//   state and the output word register, then one character per cycle
//   follows from the store's single read port while rsp_ready stays high.
// Stall: while rsp_ready is low the engine holds the current character;
//   the queue keeps taking bytes until it fills, then req_ready drops.
// Reset: synchronous, clears the queue, the line and the output valid.
module uart_line_assembler_trim_core #(
   parameter int LINE_CAPACITY = ulat_pkg::ULAT_LINE_CAPACITY
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_line_char,
   output logic            rsp_line_last
);
   import ulat_pkg::*;

   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      pop_cmd;
   logic         push;
   logic         pop;

   ulat_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   ulat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   ulat_back #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_cmd         (pop_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_char (rsp_line_char),
      .rsp_line_last (rsp_line_last)
   );

endmodule
`default_nettype wire

// ----- dv/uart_line_assembler_trim_core_tb.sv -----
`timescale 1ns / 1ps
module uart_line_assembler_trim_core_tb;
   import ulat_pkg::*;

   localparam int         LINE_CAP    = ULAT_LINE_CAPACITY;
   localparam logic [7:0] TAB_BYTE    = 8'd9;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         MAX_REPORTS = 100;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } line_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_line_char;
   logic       rsp_line_last;

   // line predictor state
   logic [6:0] held_chars [LINE_CAP];
   int         held_count = 0;
   int         text_start = 0;
   int         text_end = 0;
   bit         text_found = 1'b0;
   line_word_type line_chars_due [$];

   int mismatches = 0;
   int bytes_sent = 0;
   int chars_checked = 0;
   int lines_due = 0;
   int cycle_count = 0;
   int rsp_stall = 0;
   int rsp_hold = 0;
   bit quiet = 1'b0;

   uart_line_assembler_trim_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_line_char (rsp_line_char),
      .rsp_line_last (rsp_line_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, line_chars_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int draw_wait();
      if (quiet)
         return 0;
      return $urandom_range(0, 13);
   endfunction

   function automatic void clear_line();
      held_count = 0;
      text_start = 0;
      text_end = 0;
      text_found = 1'b0;
   endfunction

   // advance the line predictor by one accepted byte
   function automatic void absorb_byte(input logic [7:0] b);
      line_word_type w;
      if (b == CH_CR)
         return;
      if (b == CH_LF) begin
         if (text_found) begin
            for (int i = text_start; i <= text_end; i++) begin
               w.ch   = held_chars[i];
               w.last = (i == text_end);
               line_chars_due.push_back(w);
            end
            lines_due++;
         end
         clear_line();
      end else if (b >= CH_LOW && b <= CH_HIGH) begin
         if (held_count + 1 < LINE_CAP) begin
            held_chars[held_count] = b[6:0];
            if (b[6:0] != CH_SPACE) begin
               if (!text_found) begin
                  text_start = held_count;
                  text_found = 1'b1;
               end
               text_end = held_count;
            end
            held_count++;
         end else begin
            // overflow: drop the line and this byte
            clear_line();
         end
      end
   endfunction

   // receiver: random stall per word, plus an optional long hold
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_word
      line_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_chars_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected word, expected none, got char %0d last %0b",
                        $time, rsp_line_char, rsp_line_last);
         end else begin
            w = line_chars_due.pop_front();
            chars_checked++;
            if (rsp_line_char !== w.ch) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: line_char expected %0d got %0d",
                           $time, w.ch, rsp_line_char);
            end
            if (rsp_line_last !== w.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: line_last expected %0b got %0b",
                           $time, w.last, rsp_line_last);
            end
         end
         rsp_stall <= draw_wait();
      end
   end

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic put_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      absorb_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endtask

   // drop valid and step to the next rising edge
   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: b = CH_CR;
         1: b = TAB_BYTE;
         2: begin
            b = 8'($urandom_range(0, 31));
            if (b == CH_LF)
               b = 8'd0;
         end
         default: b = 8'($urandom_range(127, 255));
      endcase
      return b;
   endfunction

   task automatic send_random_line();
      int lead;
      int body;
      int trail;
      lead  = $urandom_range(0, 3);
      trail = $urandom_range(0, 3);
      body  = $urandom_range(0, 10);
      repeat (lead) put_byte(CH_SPACE);
      repeat (body) begin
         if ($urandom_range(0, 7) == 0)
            put_byte(noise_byte());
         else
            put_byte(8'($urandom_range(CH_LOW, CH_HIGH)));
      end
      repeat (trail) put_byte(CH_SPACE);
      // mostly LF, some CR LF, a few unterminated lines that run into the next
      case ($urandom_range(0, 15))
         0: ;
         1, 2, 3: begin
            put_byte(CH_CR);
            put_byte(CH_LF);
         end
         default: put_byte(CH_LF);
      endcase
   endtask

   task automatic test_directed();
      put_text("  !~  \n");
      put_byte(CH_LF);
      put_text("   \n");
      put_byte(8'd0);
      put_byte(TAB_BYTE);
      put_byte(CH_CR);
      put_byte(8'd31);
      put_byte(8'd127);
      put_byte(8'd128);
      put_byte(8'd255);
      put_text("a b\n");
      put_byte("z");
      put_byte(CH_CR);
      put_byte(CH_LF);
   endtask

   task automatic test_overflow();
      // a full line comes out whole
      repeat (LINE_CAP - 1) put_byte(8'($urandom_range(CH_LOW + 1, CH_HIGH)));
      put_byte(CH_LF);
      // one more byte than fits drops the line
      repeat (LINE_CAP - 1) put_byte(8'($urandom_range(CH_LOW, CH_HIGH)));
      put_byte("Q");
      put_text("ok\n");
   endtask

   task automatic test_random_lines();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < 20) begin
         quiet = ($urandom_range(0, 4) == 0);
         send_random_line();
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      pause_sender();
      rsp_hold = 300;
      @(negedge clock);
      quiet = 1'b1;
      repeat (2) put_text("  hold ~\n");
      quiet = 1'b0;
   endtask

   task automatic test_drain_pause();
      pause_sender();
      while (line_chars_due.size() != 0) @(posedge clock);
      @(negedge clock);
      put_text("after drain\n");
      put_byte(CH_LF);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_overflow();
      test_random_lines();
      test_backpressure();
      test_drain_pause();
      pause_sender();
      while (line_chars_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d bytes forming %0d nonblank lines, checked %0d characters",
               bytes_sent, lines_due, chars_checked);
      $display("covered trimming, blank lines, ignored bytes, overflow and long stalls");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ulat_pkg.sv
design/ulat_front.sv
design/ulat_queue.sv
design/ulat_back.sv
design/uart_line_assembler_trim_core.sv
dv/uart_line_assembler_trim_core_tb.sv
